FILE: rtl/rgbdm_pkg.sv
// Shared types, constants and helper functions of the RGB-IR demosaic core.
// No dependencies; every other file of the block except rgbdm_ram refers to this package by scoped names.
package rgbdm_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int PIXEL_W           = 16;
   localparam int SAMPLE_W          = 8;
   localparam int ROW_W             = 12;
   localparam int LINE_WIDTH_W      = 12;
   localparam int FRAME_HEIGHT_W    = 13;
   localparam int CSR_DATA_W        = 13;

   localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RESET   = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_MIN   = 13'd2;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_MAX   = 13'd4096;
   localparam logic [SAMPLE_W-1:0]       SAMPLE_MAX         = 8'hFF;

   typedef enum logic {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red_first;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
      logic [SAMPLE_W-1:0] ir;
      logic [ROW_W-1:0]    row;
      logic                frame_end;
   } pair_type;

   function automatic logic [SAMPLE_W-1:0] saturate(input logic [PIXEL_W-1:0] value);
      saturate = (|value[PIXEL_W-1:SAMPLE_W]) ? SAMPLE_MAX : value[SAMPLE_W-1:0];
   endfunction

   function automatic logic [ROW_W-1:0] height_last(input logic [FRAME_HEIGHT_W-1:0] height);
      logic [FRAME_HEIGHT_W-1:0] clamped;
      clamped = height;
      if (height < FRAME_HEIGHT_MIN) begin
         clamped = FRAME_HEIGHT_MIN;
      end else if (height > FRAME_HEIGHT_MAX) begin
         clamped = FRAME_HEIGHT_MAX;
      end
      height_last = ROW_W'(clamped - 13'd1);
   endfunction

endpackage

FILE: rtl/rgbdm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module rgbdm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rgbdm_out_stage.sv
// Output register of the demosaic core: holds one pixel pair and sends it as two transfers.
// Depends on rgbdm_pkg for the pair structure.
module rgbdm_out_stage #(
   parameter int COL_W = 11
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  rgbdm_pkg::pair_type                pair,
   input  logic [COL_W-2:0]                   col_pair,
   output logic                               can_load,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rgbdm_pkg::SAMPLE_W-1:0]     rsp_red_value,
   output logic [rgbdm_pkg::SAMPLE_W-1:0]     rsp_green_value,
   output logic [rgbdm_pkg::SAMPLE_W-1:0]     rsp_blue_value,
   output logic [rgbdm_pkg::SAMPLE_W-1:0]     rsp_ir_value,
   output logic [COL_W-1:0]                   rsp_out_column,
   output logic [rgbdm_pkg::ROW_W-1:0]        rsp_out_row,
   output logic                               rsp_frame_end,
   output logic                               rsp_run_last
);

   logic                valid_ff, valid_in;
   logic                second_ff, second_in;
   rgbdm_pkg::pair_type pair_ff;
   logic [COL_W-2:0]    col_pair_ff;

   assign can_load = !valid_ff || (second_ff && rsp_ready);

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      if (load) begin
         valid_in  = 1'b1;
         second_in = 1'b0;
      end else if (valid_ff && rsp_ready) begin
         if (second_ff) begin
            valid_in  = 1'b0;
            second_in = 1'b0;
         end else begin
            second_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pair_ff     <= pair;
         col_pair_ff <= col_pair;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_red_value   = second_ff ? pair_ff.green : pair_ff.red_first;
   assign rsp_green_value = pair_ff.green;
   assign rsp_blue_value  = pair_ff.blue;
   assign rsp_ir_value    = pair_ff.ir;
   assign rsp_out_column  = {col_pair_ff, second_ff};
   assign rsp_out_row     = pair_ff.row;
   assign rsp_frame_end   = second_ff && pair_ff.frame_end;
   assign rsp_run_last    = second_ff;

endmodule

FILE: rtl/rgbdm_core_dummy_guard.sv
// Line-geometry tracker of the demosaic core: column and row counters with end-of-line wrap.
// Depends on rgbdm_pkg for the row width.
module rgbdm_core_dummy_guard #(
   parameter int COL_W = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        frame_start,
   input  logic [COL_W-1:0]            col_last,
   input  logic [rgbdm_pkg::ROW_W-1:0] row_last,
   output logic [COL_W-1:0]            col_now,
   output logic [rgbdm_pkg::ROW_W-1:0] row_now,
   output logic                        col_odd_ff
);

   localparam int ROW_W = rgbdm_pkg::ROW_W;

   logic [COL_W-1:0]            col_ff, col_in;
   logic [rgbdm_pkg::ROW_W-1:0] row_ff, row_in;

   assign col_now    = frame_start ? '0 : col_ff;
   assign row_now    = frame_start ? '0 : row_ff;
   assign col_odd_ff = col_ff[0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (col_now >= col_last) begin
            col_in = '0;
            row_in = (row_now >= row_last) ? '0 : row_now + ROW_W'(1);
         end else begin
            col_in = col_now + COL_W'(1);
            row_in = row_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

FILE: rtl/rgbir_demosaic_core.sv
// Top level of the RGB-IR nearest-neighbor demosaic core.
// Depends on rgbdm_pkg, rgbdm_ram, rgbdm_out_stage and rgbdm_core_dummy_guard.
//
// The core accepts one raw sample per clock in raster order and keeps the previous raw line
// in a RAM of sample pairs, read when an even column arrives and written back when the odd
// column of the same pair arrives. Every odd column from raw row 1 on yields two pixels,
// which leave through an output register as two transfers, so the sustained rate is
// one sample per clock; the input stalls only while the output side holds back an
// earlier pair. The line RAM is not cleared after reset: the first raw row of a frame
// writes every entry before the next row reads it.
module rgbir_demosaic_core #(
   parameter int MAX_WIDTH = rgbdm_pkg::MAX_WIDTH_DEFAULT,
   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rgbdm_pkg::PIXEL_W-1:0]         req_pixel_value,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rgbdm_pkg::SAMPLE_W-1:0]        rsp_red_value,
   output logic [rgbdm_pkg::SAMPLE_W-1:0]        rsp_green_value,
   output logic [rgbdm_pkg::SAMPLE_W-1:0]        rsp_blue_value,
   output logic [rgbdm_pkg::SAMPLE_W-1:0]        rsp_ir_value,
   output logic [COL_W-1:0]                      rsp_out_column,
   output logic [rgbdm_pkg::ROW_W-1:0]           rsp_out_row,
   output logic                                  rsp_frame_end,
   output logic                                  rsp_run_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  rgbdm_pkg::csr_index_type              csr_index,
   input  logic [rgbdm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_W     = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
   localparam int SW         = rgbdm_pkg::SAMPLE_W;
   localparam int ROW_W      = rgbdm_pkg::ROW_W;

   function automatic logic [COL_W-1:0] width_last(
      input logic [rgbdm_pkg::LINE_WIDTH_W-1:0] line_width
   );
      int w;
      w = int'({line_width[rgbdm_pkg::LINE_WIDTH_W-1:1], 1'b0});
      if (w < 2) begin
         w = 2;
      end else if (w > MAX_WIDTH) begin
         w = MAX_WIDTH - (MAX_WIDTH % 2);
      end
      width_last = COL_W'(w - 1);
   endfunction

   logic [COL_W-1:0]            col_last_ff;
   logic [rgbdm_pkg::ROW_W-1:0] row_last_ff;
   logic [SW-1:0]               held_even_ff, held_even_in;
   logic [SW-1:0]               held_red_ff, held_red_in;

   logic                        accept;
   logic                        odd_step;
   logic                        emit;
   logic                        can_load;
   logic                        col_odd_ff;
   logic [COL_W-1:0]            col_now;
   logic [rgbdm_pkg::ROW_W-1:0] row_now;
   logic [rgbdm_pkg::ROW_W-1:0] out_row;
   logic [SW-1:0]               sample;
   logic [2*SW-1:0]             line_rd;
   logic [SW-1:0]               prev_a, prev_b, cur_a, cur_b;
   logic [SW-1:0]               e0, e1, o0, o1;
   rgbdm_pkg::pair_type         pair;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= width_last(rgbdm_pkg::LINE_WIDTH_RESET);
         row_last_ff <= rgbdm_pkg::height_last(rgbdm_pkg::FRAME_HEIGHT_RESET);
      end else if (csr_valid) begin
         case (csr_index)
            rgbdm_pkg::CSR_LINE_WIDTH: begin
               col_last_ff <= width_last(csr_wdata[rgbdm_pkg::LINE_WIDTH_W-1:0]);
            end
            rgbdm_pkg::CSR_FRAME_HEIGHT: begin
               row_last_ff <= rgbdm_pkg::height_last(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !col_odd_ff || can_load;
   assign accept    = req_valid && req_ready;
   assign sample    = rgbdm_pkg::saturate(req_pixel_value);
   assign odd_step  = col_now[0];
   assign emit      = accept && odd_step && (row_now != '0);
   assign out_row   = row_now - ROW_W'(1);

   rgbdm_core_dummy_guard #(
      .COL_W (COL_W)
   ) u_counters (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .frame_start (req_frame_start),
      .col_last    (col_last_ff),
      .row_last    (row_last_ff),
      .col_now     (col_now),
      .row_now     (row_now),
      .col_odd_ff  (col_odd_ff)
   );

   rgbdm_ram #(
      .WIDTH (2 * SW),
      .DEPTH (PAIR_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept && odd_step),
      .wr_addr (col_now[ADDR_W:1]),
      .wr_data ({cur_b, cur_a}),
      .rd_en   (accept && !odd_step),
      .rd_addr (col_now[ADDR_W:1]),
      .rd_data (line_rd)
   );

   assign prev_a = line_rd[SW-1:0];
   assign prev_b = line_rd[2*SW-1:SW];
   assign cur_a  = held_even_ff;
   assign cur_b  = sample;

   always_comb begin
      if (!out_row[0]) begin
         e0 = prev_a;
         e1 = prev_b;
         o0 = cur_a;
         o1 = cur_b;
      end else begin
         e0 = cur_a;
         e1 = cur_b;
         o0 = prev_a;
         o1 = prev_b;
      end
   end

   always_comb begin
      pair.red_first = (col_now == COL_W'(1)) ? e0 : held_red_ff;
      pair.green     = e1;
      pair.blue      = o1;
      pair.ir        = o0;
      pair.row       = out_row;
      pair.frame_end = (row_now >= row_last_ff) && (col_now >= col_last_ff);
   end

   always_comb begin
      held_even_in = held_even_ff;
      held_red_in  = held_red_ff;
      if (accept && !odd_step) begin
         held_even_in = sample;
      end
      if (emit) begin
         held_red_in = e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_even_ff <= '0;
         held_red_ff  <= '0;
      end else begin
         held_even_ff <= held_even_in;
         held_red_ff  <= held_red_in;
      end
   end

   rgbdm_out_stage #(
      .COL_W (COL_W)
   ) u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .load            (emit),
      .pair            (pair),
      .col_pair        (col_now[COL_W-1:1]),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_value   (rsp_red_value),
      .rsp_green_value (rsp_green_value),
      .rsp_blue_value  (rsp_blue_value),
      .rsp_ir_value    (rsp_ir_value),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_row     (rsp_out_row),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

FILE: tb/rgbir_demosaic_core_tb.sv
// Self-checking testbench of rgbir_demosaic_core, which needs rgbdm_pkg and the core RTL.
// A scoreboard predicts each output pixel from the accepted raw samples and the register
// settings, while random stalls on the request and response channels pace the core through many frame shapes.

typedef struct packed {
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  ir;
   logic [10:0] column;
   logic [11:0] row;
   logic        frame_end;
   logic        run_last;
} rgbir_pixel_type;

class rgbir_pixel_scoreboard;
   bit [7:0]        line_mem [2048];
   bit [10:0]       column_pos;
   bit [11:0]       row_pos;
   bit [7:0]        even_sample;
   bit [7:0]        last_red;
   bit [11:0]       width_reg;
   bit [12:0]       height_reg;
   rgbir_pixel_type pending_pixels [$];
   int              mismatches;

   function new();
      width_reg = rgbdm_pkg::LINE_WIDTH_RESET;
      height_reg = rgbdm_pkg::FRAME_HEIGHT_RESET;
   endfunction

   function void write_reg(rgbdm_pkg::csr_index_type idx, logic [12:0] data);
      if (idx == rgbdm_pkg::CSR_LINE_WIDTH) begin
         width_reg = data[11:0];
      end else begin
         height_reg = data;
      end
   endfunction

   function int unsigned active_width();
      int unsigned w;
      w = 32'(width_reg & 12'hFFE);
      if (w < 2) w = 2;
      if (w > 2048) w = 2048;
      return w;
   endfunction

   function int unsigned active_height();
      int unsigned h;
      h = 32'(height_reg);
      if (h < 2) h = 2;
      if (h > 4096) h = 4096;
      return h;
   endfunction

   // Notes one accepted raw sample and queues the pixels that it completes.
   function void take_sample(logic [15:0] pixel, logic frame_start);
      bit [7:0]        s, e0, e1, o0, o1, prev_a, prev_b;
      int unsigned     w, h, c, r;
      rgbir_pixel_type px;
      s = (pixel > 16'd255) ? 8'hFF : pixel[7:0];
      w = active_width();
      h = active_height();
      if (frame_start) begin
         column_pos = '0;
         row_pos = '0;
      end
      c = 32'(column_pos);
      r = 32'(row_pos);
      if (c % 2 == 0) begin
         even_sample = s;
      end else begin
         prev_a = line_mem[c - 1];
         prev_b = line_mem[c];
         if (r >= 1) begin
            if ((r - 1) % 2 == 0) begin
               e0 = prev_a;
               e1 = prev_b;
               o0 = even_sample;
               o1 = s;
            end else begin
               e0 = even_sample;
               e1 = s;
               o0 = prev_a;
               o1 = prev_b;
            end
            for (int k = 0; k < 2; k++) begin
               px.red = (k == 1) ? e1 : ((c == 1) ? e0 : last_red);
               px.green = e1;
               px.blue = o1;
               px.ir = o0;
               px.column = 11'(c - 1 + k);
               px.row = 12'(r - 1);
               px.frame_end = (k == 1) && (r >= h - 1) && (c >= w - 1);
               px.run_last = (k == 1);
               pending_pixels.push_back(px);
            end
            last_red = e1;
         end
         line_mem[c - 1] = even_sample;
         line_mem[c] = s;
      end
      if (c >= w - 1) begin
         column_pos = '0;
         row_pos = (r >= h - 1) ? 12'd0 : 12'(r + 1);
      end else begin
         column_pos = 11'(c + 1);
      end
   endfunction

   function void compare_field(string label, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endfunction

   function void check_pixel(rgbir_pixel_type got);
      rgbir_pixel_type want;
      if (pending_pixels.size() == 0) begin
         $display("%0t: unexpected pixel, expected none, actual column %0d row %0d",
                  $time, got.column, got.row);
         mismatches++;
         return;
      end
      want = pending_pixels.pop_front();
      compare_field("red_value", 16'(want.red), 16'(got.red));
      compare_field("green_value", 16'(want.green), 16'(got.green));
      compare_field("blue_value", 16'(want.blue), 16'(got.blue));
      compare_field("ir_value", 16'(want.ir), 16'(got.ir));
      compare_field("out_column", 16'(want.column), 16'(got.column));
      compare_field("out_row", 16'(want.row), 16'(got.row));
      compare_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
      compare_field("run_last", 16'(want.run_last), 16'(got.run_last));
   endfunction
endclass

module rgbir_demosaic_core_tb;
   localparam int STALL_MAX = 5;
   localparam int DRAIN_CYCLES = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 750;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_pixel_value = '0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_value;
   logic [7:0]  rsp_green_value;
   logic [7:0]  rsp_blue_value;
   logic [7:0]  rsp_ir_value;
   logic [10:0] rsp_out_column;
   logic [11:0] rsp_out_row;
   logic        rsp_frame_end;
   logic        rsp_run_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   rgbdm_pkg::csr_index_type csr_index = rgbdm_pkg::CSR_LINE_WIDTH;
   logic [12:0] csr_wdata = '0;

   bit req_pacing = 1'b1;
   bit rsp_pacing = 1'b1;

   rgbir_pixel_scoreboard sb = new();

   logic [15:0] directed_pixels [22] = '{
      16'h0000, 16'h00FF, 16'h0100, 16'hFFFF, 16'h0001, 16'h00FE, 16'h8000, 16'h00FF,
      16'h5555, 16'hAAAA, 16'h0080, 16'h007F, 16'h1234, 16'h0000, 16'hFFFF, 16'h00C3,
      16'h0042, 16'h0F0F, 16'h00AA, 16'h0055, 16'hF0F0, 16'h00FF
   };

   rgbir_demosaic_core u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [15:0] draw_pixel();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'd255;
         2: return 16'd256;
         3: return 16'hFFFF;
         4, 5, 6: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic [15:0] pixel, input logic frame_start);
      int gap;
      gap = req_pacing ? $urandom_range(0, STALL_MAX) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_value <= pixel;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_sample(pixel, frame_start);
   endtask

   // A negative value leaves that register as it is.
   task automatic program_regs(input int width_data, input int height_data);
      rgbdm_pkg::csr_index_type idx;
      int data;
      for (int i = 0; i < 2; i++) begin
         idx = (i == 0) ? rgbdm_pkg::CSR_LINE_WIDTH : rgbdm_pkg::CSR_FRAME_HEIGHT;
         data = (i == 0) ? width_data : height_data;
         if (data >= 0) begin
            csr_valid <= 1'b1;
            csr_index <= idx;
            csr_wdata <= 13'(data);
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
            sb.write_reg(idx, 13'(data));
         end
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A wider line starts a new frame so that no row reads line entries never written.
   task automatic run_phase(input int width_data, input int height_data, input int rows,
                            input int extra, output int count);
      int unsigned old_width;
      bit          grew;
      wait_idle();
      old_width = sb.active_width();
      program_regs(width_data, height_data);
      grew = sb.active_width() > old_width;
      req_pacing = ($urandom_range(0, 3) != 0);
      rsp_pacing = ($urandom_range(0, 3) != 0);
      count = sb.active_width() * rows + extra;
      for (int n = 0; n < count; n++) begin
         send_sample(draw_pixel(),
                     (n == 0) ? (grew || $urandom_range(0, 1) == 1)
                              : ($urandom_range(0, 63) == 0));
      end
      req_valid <= 1'b0;
   endtask

   initial begin : response_side
      int              gap;
      rgbir_pixel_type got;
      while (reset) @(posedge clock);
      forever begin
         gap = rsp_pacing ? $urandom_range(0, STALL_MAX) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = {rsp_red_value, rsp_green_value, rsp_blue_value, rsp_ir_value,
                rsp_out_column, rsp_out_row, rsp_frame_end, rsp_run_last};
         sb.check_pixel(got);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (reset) @(posedge clock);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAIL rgbir_demosaic_core");
      $finish;
   end

   initial begin : stimulus
      int random_items;
      int count;
      int width_data;
      int height_data;
      random_items = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Odd width and too small a height: frames of four by two, a wrap into a new
      // frame without a frame start, then a restart in the middle of a row.
      program_regs(5, 0);
      foreach (directed_pixels[n]) begin
         send_sample(directed_pixels[n], n == 0 || n == 18);
      end
      req_valid <= 1'b0;

      run_phase(4095, 2, 0, 24, count);
      run_phase(2, 8191, 40, 0, count);
      run_phase(13'h1006, 1, 3, 2, count);
      run_phase(1, 4096, 5, 1, count);

      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 11))
            0: width_data = 0;
            1: width_data = 1;
            2: width_data = 2 * $urandom_range(1, 8) + 1;
            3: width_data = 13'h1000 | (2 * $urandom_range(1, 8));
            4: width_data = 2 * $urandom_range(9, 32);
            default: width_data = 2 * $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 9))
            0: height_data = 0;
            1: height_data = 1;
            2: height_data = 8191;
            3: height_data = 4096;
            default: height_data = $urandom_range(2, 6);
         endcase
         case ($urandom_range(0, 5))
            0: width_data = -1;
            1: height_data = -1;
            default: ;
         endcase
         run_phase(width_data, height_data, $urandom_range(1, 8), $urandom_range(0, 7), count);
         random_items += count;
      end

      wait_idle();
      if (sb.mismatches == 0) begin
         $display("PASS rgbir_demosaic_core");
      end else begin
         $display("FAIL rgbir_demosaic_core");
      end
      $finish;
   end
endmodule
